@@ hdl/ctl_pkg.sv @@
// Shared types for the C-style token lexer: token kinds, lexer modes, the token
// record and the per-step push bundle between the lexer core and the result queue.
// No dependencies.
package ctl_pkg;

  localparam int FIELD_MAX  = 65535;
  localparam int MAX_RES    = 3;   // most tokens one byte can produce
  localparam int RES_CNT_W  = 2;
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;

  // token kinds
  localparam logic [3:0] TK_END     = 4'd0;
  localparam logic [3:0] TK_LPAREN  = 4'd1;
  localparam logic [3:0] TK_RPAREN  = 4'd2;
  localparam logic [3:0] TK_SEMI    = 4'd3;
  localparam logic [3:0] TK_COLON   = 4'd4;
  localparam logic [3:0] TK_COMMA   = 4'd5;
  localparam logic [3:0] TK_STAR    = 4'd6;
  localparam logic [3:0] TK_LBRACK  = 4'd7;
  localparam logic [3:0] TK_RBRACK  = 4'd8;
  localparam logic [3:0] TK_LBRACE  = 4'd9;
  localparam logic [3:0] TK_RBRACE  = 4'd10;
  localparam logic [3:0] TK_ASSIGN  = 4'd11;
  localparam logic [3:0] TK_STRING  = 4'd12;
  localparam logic [3:0] TK_IDENT   = 4'd13;
  localparam logic [3:0] TK_NUMBER  = 4'd14;
  localparam logic [3:0] TK_UNKNOWN = 4'd15;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_SLASH,
    MODE_MINUS,
    MODE_LINE,
    MODE_BLOCK,
    MODE_BLOCK_STAR,
    MODE_STRING,
    MODE_STRING_ESC,
    MODE_IDENT,
    MODE_NUMBER
  } mode_e;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        final_token;
  } tok_t;

  // Tokens produced by one lexer step, packed from index 0.
  typedef struct packed {
    logic [RES_CNT_W-1:0]   count;
    tok_t [MAX_RES-1:0]     tok;
  } push_t;

endpackage

@@ hdl/ctl_if.sv @@
// Valid/ready channel interfaces of the token lexer: the byte stream in and
// the token stream out. No dependencies.
interface ctl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_byte;

  modport source (output valid, output char_byte, output last_byte, input ready);
  modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

interface ctl_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        final_token;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output final_token, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input final_token, output ready);
endinterface

@@ hdl/ctl_lex_core.sv @@
// Lexer state machine: one byte per enabled step, up to three tokens out.
// Depends on ctl_pkg.
module ctl_lex_core #(
  parameter int OFFSET_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_en_i,
  input  logic [7:0]    char_byte_i,
  input  logic          last_byte_i,
  output ctl_pkg::push_t push_o
);
  import ctl_pkg::*;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

  function automatic logic is_space(logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_eol(logic [7:0] b);
    return b == 8'h0A || b == 8'h0D;
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic [3:0] punct_kind(logic [7:0] b);
    logic [3:0] k;
    case (b)
      8'h28:   k = TK_LPAREN;
      8'h29:   k = TK_RPAREN;
      8'h3B:   k = TK_SEMI;
      8'h3A:   k = TK_COLON;
      8'h2C:   k = TK_COMMA;
      8'h2A:   k = TK_STAR;
      8'h5B:   k = TK_LBRACK;
      8'h5D:   k = TK_RBRACK;
      8'h7B:   k = TK_LBRACE;
      8'h7D:   k = TK_RBRACE;
      8'h3D:   k = TK_ASSIGN;
      default: k = TK_END;
    endcase
    return k;
  endfunction

  function automatic logic [15:0] sat_off(logic [OFFSET_BITS-1:0] v);
    return (v > OFFSET_BITS'(FIELD_MAX)) ? 16'hFFFF : 16'(v);
  endfunction

  mode_e                  mode_q, mode_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [15:0]            len_q, len_d;

  // per-byte step, before end-of-stream handling
  mode_e                  s_mode;
  logic [OFFSET_BITS-1:0] s_start;
  logic [15:0]            s_len;
  logic                   close_en;
  logic [3:0]             close_kind;
  logic [15:0]            close_len;
  logic                   idle_run;
  logic                   idle_emit;
  logic [3:0]             idle_kind;

  logic                   b_zero;
  logic                   finish;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [15:0]            len_bump;
  mode_e                  f_mode;
  logic [OFFSET_BITS-1:0] f_start;
  logic [15:0]            f_len;
  logic [OFFSET_BITS-1:0] end_pos;

  assign b_zero   = char_byte_i == 8'h00;
  assign finish   = b_zero || last_byte_i;
  assign pos_inc  = (pos_q < POS_MAX) ? pos_q + OFFSET_BITS'(1) : pos_q;
  assign len_bump = (len_q < 16'hFFFF) ? len_q + 16'd1 : len_q;

  // a zero byte ends the stream without being lexed
  assign f_mode   = b_zero ? mode_q  : s_mode;
  assign f_start  = b_zero ? start_q : s_start;
  assign f_len    = b_zero ? len_q   : s_len;
  assign end_pos  = b_zero ? pos_q   : pos_inc;

  always_comb begin
    s_mode     = mode_q;
    s_start    = start_q;
    s_len      = len_q;
    close_en   = 1'b0;
    close_kind = TK_UNKNOWN;
    close_len  = len_q;
    idle_run   = 1'b0;
    case (mode_q)
      MODE_SLASH: begin
        if (char_byte_i == CH_SLASH) begin
          s_mode = MODE_LINE;
        end else if (char_byte_i == CH_STAR) begin
          s_mode = MODE_BLOCK;
        end else begin
          close_en  = 1'b1;
          close_len = 16'd1;
          idle_run  = 1'b1;
        end
      end
      MODE_MINUS: begin
        if (is_digit(char_byte_i)) begin
          s_mode = MODE_NUMBER;
          s_len  = len_bump;
        end else begin
          close_en  = 1'b1;
          close_len = 16'd1;
          idle_run  = 1'b1;
        end
      end
      MODE_LINE: begin
        if (is_eol(char_byte_i)) s_mode = MODE_IDLE;
      end
      MODE_BLOCK: begin
        if (char_byte_i == CH_STAR) s_mode = MODE_BLOCK_STAR;
      end
      MODE_BLOCK_STAR: begin
        if (char_byte_i == CH_SLASH) s_mode = MODE_IDLE;
        else if (char_byte_i != CH_STAR) s_mode = MODE_BLOCK;
      end
      MODE_STRING: begin
        if (char_byte_i == CH_QUOTE) begin
          close_en   = 1'b1;
          close_kind = TK_STRING;
          s_mode     = MODE_IDLE;
        end else begin
          s_len = len_bump;
          if (char_byte_i == CH_BSLASH) s_mode = MODE_STRING_ESC;
        end
      end
      MODE_STRING_ESC: begin
        s_len  = len_bump;
        s_mode = MODE_STRING;
      end
      MODE_IDENT: begin
        if (is_letter(char_byte_i) || is_digit(char_byte_i) || char_byte_i == CH_UNDER) begin
          s_len = len_bump;
        end else begin
          close_en   = 1'b1;
          close_kind = TK_IDENT;
          idle_run   = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(char_byte_i) || char_byte_i == CH_DOT) begin
          s_len = len_bump;
        end else begin
          close_en   = 1'b1;
          close_kind = TK_NUMBER;
          idle_run   = 1'b1;
        end
      end
      default: idle_run = 1'b1;
    endcase

    // byte seen between tokens
    idle_emit = 1'b0;
    idle_kind = TK_UNKNOWN;
    if (idle_run) begin
      s_mode = MODE_IDLE;
      if (is_space(char_byte_i)) begin
        idle_emit = 1'b0;
      end else if (punct_kind(char_byte_i) != TK_END) begin
        idle_emit = 1'b1;
        idle_kind = punct_kind(char_byte_i);
      end else if (char_byte_i == CH_SLASH || char_byte_i == CH_MINUS) begin
        s_mode  = (char_byte_i == CH_SLASH) ? MODE_SLASH : MODE_MINUS;
        s_start = pos_q;
        s_len   = 16'd1;
      end else if (char_byte_i == CH_QUOTE) begin
        s_mode  = MODE_STRING;
        s_start = pos_inc;
        s_len   = 16'd0;
      end else if (is_letter(char_byte_i) || is_digit(char_byte_i)) begin
        s_mode  = is_letter(char_byte_i) ? MODE_IDENT : MODE_NUMBER;
        s_start = pos_q;
        s_len   = 16'd1;
      end else begin
        idle_emit = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    start_d = start_q;
    len_d   = len_q;
    if (step_en_i) begin
      if (finish) begin
        mode_d  = MODE_IDLE;
        pos_d   = '0;
        start_d = '0;
        len_d   = '0;
      end else begin
        mode_d  = s_mode;
        pos_d   = pos_inc;
        start_d = s_start;
        len_d   = s_len;
      end
    end
  end

  // tokens of this step, packed from slot 0
  always_comb begin
    logic [RES_CNT_W-1:0] n;
    n      = '0;
    push_o = '0;
    if (step_en_i) begin
      if (!b_zero && close_en) begin
        push_o.tok[n] = '{close_kind, sat_off(start_q), close_len, 1'b0};
        n = n + 2'd1;
      end
      if (!b_zero && idle_emit) begin
        push_o.tok[n] = '{idle_kind, sat_off(pos_q), 16'd1, 1'b0};
        n = n + 2'd1;
      end
      if (finish) begin
        case (f_mode)
          MODE_SLASH, MODE_MINUS: begin
            push_o.tok[n] = '{TK_UNKNOWN, sat_off(f_start), 16'd1, 1'b0};
            n = n + 2'd1;
          end
          MODE_STRING, MODE_STRING_ESC: begin
            push_o.tok[n] = '{TK_STRING, sat_off(f_start), f_len, 1'b0};
            n = n + 2'd1;
          end
          MODE_IDENT: begin
            push_o.tok[n] = '{TK_IDENT, sat_off(f_start), f_len, 1'b0};
            n = n + 2'd1;
          end
          MODE_NUMBER: begin
            push_o.tok[n] = '{TK_NUMBER, sat_off(f_start), f_len, 1'b0};
            n = n + 2'd1;
          end
          default: n = n;
        endcase
        push_o.tok[n] = '{TK_END, sat_off(end_pos), 16'd1, 1'b1};
        n = n + 2'd1;
      end
    end
    push_o.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
    end else begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
    end
  end

  a_finish_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en_i && finish) |=> (pos_q == '0 && mode_q == MODE_IDLE && len_q == '0))
    else $error("stream end did not restart the lexer");

  a_finish_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en_i && finish) |-> (push_o.count != '0))
    else $error("stream end produced no end token");

  a_no_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_en_i |-> (push_o.count == '0))
    else $error("tokens produced without a step");

  a_pos_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en_i && !finish) |=> (pos_q >= $past(pos_q)))
    else $error("byte position moved backward");

endmodule

@@ hdl/ctl_result_fifo.sv @@
// Token queue: takes up to three tokens per cycle from the lexer core and
// hands them out one per transfer. Depends on ctl_pkg and ctl_if.
module ctl_result_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ctl_pkg::push_t push_i,
  output logic           space_o,
  ctl_token_if.source    token_o
);
  import ctl_pkg::*;

  tok_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             pop;
  tok_t             head;

  assign space_o = count_q <= CNT_W'(FIFO_DEPTH - MAX_RES);
  assign pop     = token_o.valid && token_o.ready;
  assign head    = mem_q[rd_ptr_q];

  assign token_o.valid        = count_q != '0;
  assign token_o.token_kind   = head.token_kind;
  assign token_o.token_start  = head.token_start;
  assign token_o.token_length = head.token_length;
  assign token_o.final_token  = head.final_token;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_i.count);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    count_d  = count_q + CNT_W'(push_i.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (RES_CNT_W'(i) < push_i.count) begin
        mem_q[wr_ptr_q + PTR_W'(i)] <= push_i.tok[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != '0) |-> space_o)
    else $error("tokens pushed into a full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("queue fill count out of range");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.count == '0) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("queue count did not drop on transfer");

endmodule

@@ hdl/c_style_token_lexer.sv @@
// Top level of the C-style token lexer: input register, lexer core and
// token queue. Depends on ctl_pkg, ctl_if, ctl_lex_core, ctl_result_fifo.
//
//   channel   dir  payload                                            handshake
//   byte_i    in   char_byte[7:0], last_byte                          valid/ready
//   token_o   out  token_kind[3:0], token_start[15:0],                valid/ready
//                  token_length[15:0], final_token
//
// One byte per cycle while the queue has space; a byte waits in the input
// register until it is lexed, and its tokens are then written to the queue.
// A byte yields up to three tokens; token_o drains one per cycle while ready
// is high from an eight-entry queue; byte_i stalls while under 3 slots are free.
// Reset puts the lexer between tokens at offset zero with an empty queue.
module c_style_token_lexer #(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ctl_byte_if.sink    byte_i,
  ctl_token_if.source token_o
);
  import ctl_pkg::*;

  logic       in_vq;
  logic [7:0] byte_q;
  logic       last_q;
  logic       space;
  logic       step_en;
  push_t      push;

  assign step_en      = in_vq && space;
  assign byte_i.ready = !in_vq || step_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (byte_i.ready) begin
      in_vq <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      byte_q <= byte_i.char_byte;
      last_q <= byte_i.last_byte;
    end
  end

  ctl_lex_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (step_en),
    .char_byte_i (byte_q),
    .last_byte_i (last_q),
    .push_o      (push)
  );

  ctl_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .token_o (token_o)
  );

  a_held_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vq && !step_en) |=> (in_vq && byte_q == $past(byte_q) && last_q == $past(last_q)))
    else $error("stalled input byte was lost or changed");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vq |-> byte_i.ready)
    else $error("input refused with an empty input register");

  a_step_needs_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en |-> space)
    else $error("byte lexed without queue space");

endmodule
